// ===== rtl/tcra_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcra_pkg
// Shared types and constants for the three-class runway arbiter.
// ----------------------------------------------------------------------------
package tcra_pkg;

    localparam int NCLS    = 3;
    localparam int ID_BITS = 10;
    localparam int CFG_DW  = 8;
    localparam int CFG_IW  = 2;
    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 16;

    localparam logic [1:0] CLS_EMG  = 2'd0;
    localparam logic [1:0] CLS_LAND = 2'd1;
    localparam logic [1:0] CLS_DEP  = 2'd2;

    localparam logic [CFG_IW-1:0] CFG_MAX_WAIT = 2'd0;
    localparam logic [CFG_IW-1:0] CFG_BACKLOG  = 2'd1;
    localparam logic [CFG_IW-1:0] CFG_HOLD     = 2'd2;

    localparam logic [7:0] WAIT_MAX = 8'd255;

    typedef struct packed {
        logic       granted;
        logic [1:0] gcls;
        logic       busy;
        logic       dropped;
        logic       wr_en;
    } step_flags_t;

endpackage

// ===== rtl/tcra_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcra_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module tcra_ram #(
    parameter int WIDTH = 10,
    parameter int DEPTH = 48
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/tcra_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcra_ctrl
// Queue pointers, runway hold timer, wait counter and the grant decision.
// ----------------------------------------------------------------------------
module tcra_ctrl
    import tcra_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16,
    parameter int PW          = 4
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          step,
    input  logic          op,
    input  logic [1:0]    cls,
    input  logic [7:0]    max_wait,
    input  logic [4:0]    backlog_limit,
    input  logic [7:0]    hold_ticks,
    output step_flags_t   flags,
    output logic [PW+1:0] rd_addr,
    output logic [PW+1:0] wr_addr
);

    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    logic [CW-1:0] count_reg [NCLS];
    logic [CW-1:0] count_next [NCLS];
    logic [PW-1:0] head_reg [NCLS];
    logic [PW-1:0] head_next [NCLS];
    logic [PW-1:0] tail [NCLS];
    logic [CW:0]   tail_sum [NCLS];
    logic [NCLS-1:0] full;
    logic [NCLS-1:0] push;
    logic [NCLS-1:0] pop;

    logic [7:0] hold_reg;
    logic [7:0] hold_next;
    logic [1:0] holder_reg;
    logic [1:0] holder_next;
    logic [7:0] wait_reg;
    logic [7:0] wait_next;

    logic [1:0] eff_cls;
    logic       expire;
    logic [7:0] hold_mid;
    logic       dropped;
    logic       granted;
    logic [1:0] pick;
    logic       dep_low;

    always_comb
    begin
        eff_cls = (cls == 2'd3) ? CLS_DEP : cls;
        expire  = !op && (hold_reg == 8'd1);
        hold_mid = (!op && hold_reg != 8'd0) ? hold_reg - 8'd1 : hold_reg;
        if (op)
        begin
            wait_next = wait_reg;
        end
        else if (expire && holder_reg == CLS_LAND)
        begin
            wait_next = 8'd0;
        end
        else
        begin
            wait_next = (wait_reg != WAIT_MAX) ? wait_reg + 8'd1 : wait_reg;
        end

        dropped = 1'b0;
        for (int c = 0; c < NCLS; c++)
        begin
            full[c] = count_reg[c] == CW'(QUEUE_DEPTH);
            push[c] = op && (eff_cls == 2'(c)) && !full[c];
            pop[c]  = expire && (holder_reg == 2'(c));
            dropped = dropped | (op && (eff_cls == 2'(c)) && full[c]);
            count_next[c] = count_reg[c] + CW'(push[c]) - CW'(pop[c]);
            if (pop[c])
            begin
                head_next[c] = (head_reg[c] == PW'(QUEUE_DEPTH - 1)) ? '0
                                                                     : head_reg[c] + 1'b1;
            end
            else
            begin
                head_next[c] = head_reg[c];
            end
            tail_sum[c] = (CW+1)'(head_reg[c]) + (CW+1)'(count_reg[c]);
            tail[c] = (tail_sum[c] >= (CW+1)'(QUEUE_DEPTH))
                      ? PW'(tail_sum[c] - (CW+1)'(QUEUE_DEPTH)) : PW'(tail_sum[c]);
        end

        dep_low = 9'(count_next[2]) <= 9'(backlog_limit);
        granted = 1'b0;
        pick    = CLS_EMG;
        if (hold_mid == 8'd0)
        begin
            priority if (count_next[0] != '0)
            begin
                granted = 1'b1;
                pick    = CLS_EMG;
            end
            else if (count_next[1] != '0 && (dep_low || wait_next >= max_wait))
            begin
                granted = 1'b1;
                pick    = CLS_LAND;
            end
            else if (count_next[2] != '0 && (count_next[1] == '0 || !dep_low))
            begin
                granted = 1'b1;
                pick    = CLS_DEP;
            end
        end

        hold_next   = granted ? ((hold_ticks != 8'd0) ? hold_ticks : 8'd1) : hold_mid;
        holder_next = granted ? pick : holder_reg;

        unique case (pick)
            CLS_LAND: rd_addr = {CLS_LAND, head_next[1]};
            CLS_DEP:  rd_addr = {CLS_DEP, head_next[2]};
            default:  rd_addr = {CLS_EMG, head_next[0]};
        endcase
        unique case (eff_cls)
            CLS_LAND: wr_addr = {CLS_LAND, tail[1]};
            CLS_DEP:  wr_addr = {CLS_DEP, tail[2]};
            default:  wr_addr = {CLS_EMG, tail[0]};
        endcase

        flags.granted = granted;
        flags.gcls    = pick;
        flags.busy    = hold_next != 8'd0;
        flags.dropped = dropped;
        flags.wr_en   = op && !dropped;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < NCLS; c++)
            begin
                count_reg[c] <= '0;
                head_reg[c]  <= '0;
            end
            hold_reg   <= 8'd0;
            holder_reg <= CLS_EMG;
            wait_reg   <= 8'd0;
        end
        else if (step)
        begin
            for (int c = 0; c < NCLS; c++)
            begin
                count_reg[c] <= count_next[c];
                head_reg[c]  <= head_next[c];
            end
            hold_reg   <= hold_next;
            holder_reg <= holder_next;
            wait_reg   <= wait_next;
        end
    end

endmodule

// ===== rtl/three_class_runway_arbiter_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// three_class_runway_arbiter_core
// Priority runway arbiter with three request queues, a departure backlog
// limit and a wait counter that keeps landing requests from starving.
// ----------------------------------------------------------------------------
// Input items arrive on the s_ stream. The tuser bit selects the kind of item:
// zero is one time tick, one is a new request whose id and class are in
// tdata. Every input item produces exactly one result item on the m_ stream,
// carrying the grant issued in that step (if any), the runway busy flag and
// the drop flag for a request that found its queue full.
// The queued ids live in one RAM with a registered read port. When an item is
// accepted, the head of the granted queue is read in the same cycle, and the
// result then passes through the fetch stage into the output register.
// The block takes no new item until its result has left the fetch stage.
// When the receiver stalls, the finished result waits in the output register
// and a further accepted item waits in the fetch stage until it drains.
// Reset empties all queues, frees the runway, clears the wait counter and
// restores the configuration registers to their defaults; no clearing pass
// is needed. Configuration is written through cfg_we, cfg_index, cfg_data.
// ----------------------------------------------------------------------------
module three_class_runway_arbiter_core
    import tcra_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16,
    parameter int ID_WIDTH    = 10
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // req_id[9:0], req_class[11:10], zero padding
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    // op
    input  logic                   s_tuser,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // grant_valid[0], grant_id[10:1], grant_class[12:11], runway_busy[13],
    // dropped[14], zero padding
    output logic [OUT_TDATA_W-1:0] m_tdata,
    input  logic                   cfg_we,
    input  logic [CFG_IW-1:0]      cfg_index,
    input  logic [CFG_DW-1:0]      cfg_data
);

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int RAM_DEPTH = 3 * (1 << PW);

    localparam logic ST_IDLE  = 1'b0;
    localparam logic ST_FETCH = 1'b1;

    logic [7:0] max_wait_reg;
    logic [4:0] backlog_reg;
    logic [7:0] hold_ticks_reg;

    logic        state_reg;
    logic        state_next;
    step_flags_t flags;
    step_flags_t flags_reg;
    logic        fwd_reg;
    logic [ID_WIDTH-1:0] fwd_id_reg;
    logic [ID_WIDTH-1:0] id_in;
    logic [ID_WIDTH-1:0] rdata;
    logic [ID_WIDTH-1:0] gid;
    logic [ID_BITS-1:0]  out_id;
    logic [PW+1:0] rd_addr;
    logic [PW+1:0] wr_addr;
    logic          accept;
    logic          load;
    logic          m_tvalid_reg;
    logic [OUT_TDATA_W-1:0] m_tdata_reg;

    assign s_tready = state_reg == ST_IDLE;
    assign accept   = s_tvalid && s_tready;
    assign load     = (state_reg == ST_FETCH) && (!m_tvalid_reg || m_tready);
    assign id_in    = ID_WIDTH'(s_tdata[ID_BITS-1:0]);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_wait_reg   <= 8'd3;
            backlog_reg    <= 5'd5;
            hold_ticks_reg <= 8'd2;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_MAX_WAIT: max_wait_reg   <= cfg_data;
                CFG_BACKLOG:  backlog_reg    <= cfg_data[4:0];
                CFG_HOLD:     hold_ticks_reg <= cfg_data;
                default:      ;
            endcase
        end
    end

    tcra_ctrl #(
        .QUEUE_DEPTH(QUEUE_DEPTH),
        .PW(PW)
    ) u_ctrl (
        .clk(clk),
        .rst_n(rst_n),
        .step(accept),
        .op(s_tuser),
        .cls(s_tdata[ID_BITS+1:ID_BITS]),
        .max_wait(max_wait_reg),
        .backlog_limit(backlog_reg),
        .hold_ticks(hold_ticks_reg),
        .flags(flags),
        .rd_addr(rd_addr),
        .wr_addr(wr_addr)
    );

    tcra_ram #(
        .WIDTH(ID_WIDTH),
        .DEPTH(RAM_DEPTH)
    ) u_ram (
        .clk(clk),
        .we(accept && flags.wr_en),
        .waddr(wr_addr),
        .wdata(id_in),
        .re(accept),
        .raddr(rd_addr),
        .rdata(rdata)
    );

    // A request pushed into an empty queue may be granted in the same step.
    assign gid    = fwd_reg ? fwd_id_reg : rdata;
    assign out_id = flags_reg.granted ? ID_BITS'(gid) : '0;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (accept) state_next = ST_FETCH;
            ST_FETCH: if (load) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (load)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            flags_reg  <= flags;
            fwd_reg    <= flags.wr_en && (wr_addr == rd_addr);
            fwd_id_reg <= id_in;
        end
        if (load)
        begin
            m_tdata_reg <= {1'b0, flags_reg.dropped, flags_reg.busy, flags_reg.gcls,
                            out_id, flags_reg.granted};
        end
    end

    a_accept_fetch: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg == ST_FETCH)
        else $error("accepted item did not enter the fetch stage");

    a_grant_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid_reg && m_tdata_reg[0]) |-> m_tdata_reg[13])
        else $error("grant issued without the runway being busy");

    a_no_grant_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid_reg && !m_tdata_reg[0]) |-> (m_tdata_reg[12:1] == '0))
        else $error("grant fields not zero without a grant");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FETCH && m_tvalid_reg && !m_tready) |=> state_reg == ST_FETCH)
        else $error("fetch stage left while the output was stalled");

endmodule
